// ===== rtl/iebm_pkg.sv =====
// shared types and constants for the eeprom byte master
package iebm_pkg;

    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int DEV_W  = 7;
    localparam int TMO_W  = 8;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // request codes of one tick
    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_SPARE = 2'd3
    } op_t;

    // register index taken from the word address
    typedef enum logic {
        REG_DEVICE_ADDRESS = 1'b0,
        REG_ACK_TIMEOUT    = 1'b1
    } reg_idx_t;

    localparam logic [DEV_W-1:0] DEVICE_ADDRESS_RESET = 7'd80;
    localparam logic [TMO_W-1:0] ACK_TIMEOUT_RESET    = 8'd250;

    // one result beat
    typedef struct packed {
        logic              scl_level;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_byte_out;
        logic              nack_error;
    } res_t;

endpackage

// ===== rtl/iebm_if.sv =====
// valid/ready channels for tick beats and result beats
interface iebm_in_if;
    logic                        valid;
    logic                        ready;
    logic [iebm_pkg::OP_W-1:0]   operation;
    logic [iebm_pkg::BYTE_W-1:0] mem_address;
    logic [iebm_pkg::BYTE_W-1:0] write_data;
    logic                        sda_in;

    modport source (output valid, operation, mem_address, write_data, sda_in, input ready);
    modport sink (input valid, operation, mem_address, write_data, sda_in, output ready);
endinterface

interface iebm_out_if;
    logic                        valid;
    logic                        ready;
    logic                        scl_level;
    logic                        sda_drive;
    logic                        busy_res;
    logic                        done_res;
    logic [iebm_pkg::BYTE_W-1:0] read_byte_out;
    logic                        nack_error;

    modport source (output valid, scl_level, sda_drive, busy_res, done_res, read_byte_out,
                    nack_error, input ready);
    modport sink (input valid, scl_level, sda_drive, busy_res, done_res, read_byte_out,
                  nack_error, output ready);
endinterface

// ===== rtl/i2c_eeprom_byte_master.sv =====
// top level: tick-driven i2c master for byte write and random read of a serial eeprom
//
// Every input beat is one bus tick and gives exactly one result beat with the scl and sda
// levels for that tick, plus busy, done, read byte and nack flags. A beat is taken in any
// cycle the skid slot is free, so one tick per clock is sustained while results are taken;
// each result is registered in the output register, or in the skid slot while the output
// is held. The rate is set by the single next-state block, which moves the bus sequencer
// by one phase step per tick. A byte write is start, device write byte, memory address,
// data, stop; a random read adds a repeated start, the device read byte, eight clocked-in
// bits and a master nack clock before stop. Each acknowledge is awaited for up to
// ack_timeout ticks (register at byte 4), then stop is sent with nack_error. The device
// address register lies at byte 0. Write configuration only while no transfer runs.
module i2c_eeprom_byte_master (
    input  logic                           clk,
    input  logic                           rst_n,
    iebm_in_if.sink                        in_ch,
    iebm_out_if.source                     out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iebm_pkg::PADDR_W-1:0]   paddr,
    input  logic [iebm_pkg::PDATA_W-1:0]   pwdata,
    output logic [iebm_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    // bus sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_START     = 5'd1,
        PH_SEND_DEVW = 5'd2,
        PH_ACK_DEVW  = 5'd3,
        PH_SEND_MEM  = 5'd4,
        PH_ACK_MEM   = 5'd5,
        PH_SEND_DATA = 5'd6,
        PH_ACK_DATA  = 5'd7,
        PH_RESTART   = 5'd8,
        PH_SEND_DEVR = 5'd9,
        PH_ACK_DEVR  = 5'd10,
        PH_READ      = 5'd11,
        PH_MNACK     = 5'd12,
        PH_STOP      = 5'd13,
        PH_STOP_FAIL = 5'd14
    } phase_t;

    logic [iebm_pkg::DEV_W-1:0]  device_address_reg;
    logic [iebm_pkg::TMO_W-1:0]  ack_timeout_reg;

    phase_t                      phase_reg, phase_next;
    logic [3:0]                  bit_count_reg, bit_count_next;
    logic [iebm_pkg::BYTE_W-1:0] shift_reg_reg, shift_reg_next;
    logic [iebm_pkg::TMO_W-1:0]  wait_count_reg, wait_count_next;
    logic [iebm_pkg::BYTE_W-1:0] held_address_reg, held_address_next;
    logic [iebm_pkg::BYTE_W-1:0] held_data_reg, held_data_next;
    logic                        is_read_reg, is_read_next;

    iebm_pkg::res_t              res;
    iebm_pkg::res_t              out_reg, skid_reg;
    logic                        out_valid_reg, skid_valid_reg;

    logic                        in_fire;
    logic                        out_fire;
    logic                        cfg_write;
    iebm_pkg::op_t               op;
    logic                        sda_in;
    logic [iebm_pkg::BYTE_W-1:0] dev_write_byte;

    assign in_fire   = in_ch.valid && in_ch.ready;
    assign out_fire  = out_ch.valid && out_ch.ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign op        = iebm_pkg::op_t'(in_ch.operation);
    assign sda_in    = in_ch.sda_in;
    assign dev_write_byte = {device_address_reg, 1'b0};

    // config port
    assign pready = 1'b1;
    always_comb
    begin
        case (iebm_pkg::reg_idx_t'(paddr[2]))
            iebm_pkg::REG_DEVICE_ADDRESS:
                prdata = {{(iebm_pkg::PDATA_W-iebm_pkg::DEV_W){1'b0}}, device_address_reg};
            iebm_pkg::REG_ACK_TIMEOUT:
                prdata = {{(iebm_pkg::PDATA_W-iebm_pkg::TMO_W){1'b0}}, ack_timeout_reg};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= iebm_pkg::DEVICE_ADDRESS_RESET;
            ack_timeout_reg    <= iebm_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (iebm_pkg::reg_idx_t'(paddr[2]))
                iebm_pkg::REG_DEVICE_ADDRESS:
                    device_address_reg <= pwdata[iebm_pkg::DEV_W-1:0];
                iebm_pkg::REG_ACK_TIMEOUT:
                    ack_timeout_reg <= pwdata[iebm_pkg::TMO_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // next state and result of one tick
    always_comb
    begin
        phase_t     ph;
        logic [3:0] bc;
        logic [7:0] wc_inc;

        ph                = phase_reg;
        bc                = bit_count_reg;
        wc_inc            = wait_count_reg + 8'd1;
        shift_reg_next    = shift_reg_reg;
        wait_count_next   = wait_count_reg;
        held_address_next = held_address_reg;
        held_data_next    = held_data_reg;
        is_read_next      = is_read_reg;
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        res               = '{scl_level: 1'b1, sda_drive: 1'b1, busy_res: 1'b1,
                              done_res: 1'b0, read_byte_out: '0, nack_error: 1'b0};

        // request taken in idle starts the transfer this same tick
        if (phase_reg == PH_IDLE)
        begin
            if (op == iebm_pkg::OP_WRITE || op == iebm_pkg::OP_READ)
            begin
                held_address_next = in_ch.mem_address;
                held_data_next    = in_ch.write_data;
                is_read_next      = (op == iebm_pkg::OP_READ);
                ph                = PH_START;
                bc                = 4'd0;
                phase_next        = PH_START;
                bit_count_next    = 4'd0;
            end
            else
            begin
                res.busy_res = 1'b0;
            end
        end

        case (ph)
            PH_IDLE:
                ;
            PH_START:
            begin
                if (bc == 4'd0)
                begin
                    bit_count_next = 4'd1;
                end
                else
                begin
                    res.sda_drive  = 1'b0;
                    shift_reg_next = dev_write_byte;
                    phase_next     = PH_SEND_DEVW;
                    bit_count_next = 4'd0;
                end
            end
            PH_SEND_DEVW, PH_SEND_MEM, PH_SEND_DATA, PH_SEND_DEVR:
            begin
                res.scl_level = bc[0];
                res.sda_drive = shift_reg_reg[7];
                if (bc[0])
                    shift_reg_next = {shift_reg_reg[6:0], 1'b0};
                if (bc == 4'd15)
                begin
                    bit_count_next = 4'd0;
                    case (ph)
                        PH_SEND_DEVW: phase_next = PH_ACK_DEVW;
                        PH_SEND_MEM:  phase_next = PH_ACK_MEM;
                        PH_SEND_DATA: phase_next = PH_ACK_DATA;
                        default:      phase_next = PH_ACK_DEVR;
                    endcase
                end
                else
                begin
                    bit_count_next = bc + 4'd1;
                end
            end
            PH_ACK_DEVW, PH_ACK_MEM, PH_ACK_DATA, PH_ACK_DEVR:
            begin
                if (bc == 4'd0)
                begin
                    res.scl_level   = 1'b0;
                    wait_count_next = '0;
                    bit_count_next  = 4'd1;
                end
                else if (!sda_in)
                begin
                    bit_count_next = 4'd0;
                    case (ph)
                        PH_ACK_DEVW:
                        begin
                            shift_reg_next = held_address_reg;
                            phase_next     = PH_SEND_MEM;
                        end
                        PH_ACK_MEM:
                        begin
                            if (is_read_reg)
                            begin
                                phase_next = PH_RESTART;
                            end
                            else
                            begin
                                shift_reg_next = held_data_reg;
                                phase_next     = PH_SEND_DATA;
                            end
                        end
                        PH_ACK_DATA:
                            phase_next = PH_STOP;
                        default:
                        begin
                            shift_reg_next = '0;
                            phase_next     = PH_READ;
                        end
                    endcase
                end
                else
                begin
                    wait_count_next = wc_inc;
                    if (wc_inc >= ack_timeout_reg)
                    begin
                        phase_next     = PH_STOP_FAIL;
                        bit_count_next = 4'd0;
                    end
                end
            end
            PH_RESTART:
            begin
                if (bc == 4'd0)
                begin
                    res.scl_level  = 1'b0;
                    bit_count_next = 4'd1;
                end
                else if (bc == 4'd1)
                begin
                    bit_count_next = 4'd2;
                end
                else
                begin
                    res.sda_drive  = 1'b0;
                    shift_reg_next = {device_address_reg, 1'b1};
                    phase_next     = PH_SEND_DEVR;
                    bit_count_next = 4'd0;
                end
            end
            PH_READ:
            begin
                res.scl_level = bc[0];
                if (bc[0])
                    shift_reg_next = {shift_reg_reg[6:0], sda_in};
                if (bc == 4'd15)
                begin
                    phase_next     = PH_MNACK;
                    bit_count_next = 4'd0;
                end
                else
                begin
                    bit_count_next = bc + 4'd1;
                end
            end
            PH_MNACK:
            begin
                if (bc == 4'd0)
                begin
                    res.scl_level  = 1'b0;
                    bit_count_next = 4'd1;
                end
                else
                begin
                    phase_next     = PH_STOP;
                    bit_count_next = 4'd0;
                end
            end
            PH_STOP, PH_STOP_FAIL:
            begin
                if (bc == 4'd0)
                begin
                    res.scl_level  = 1'b0;
                    res.sda_drive  = 1'b0;
                    bit_count_next = 4'd1;
                end
                else if (bc == 4'd1)
                begin
                    res.sda_drive  = 1'b0;
                    bit_count_next = 4'd2;
                end
                else
                begin
                    res.done_res = 1'b1;
                    if (ph == PH_STOP_FAIL)
                        res.nack_error = 1'b1;
                    else if (is_read_reg)
                        res.read_byte_out = shift_reg_reg;
                    phase_next     = PH_IDLE;
                    bit_count_next = 4'd0;
                end
            end
            default:
            begin
                // unused phase code falls back to idle
                res.busy_res   = 1'b0;
                phase_next     = PH_IDLE;
                bit_count_next = 4'd0;
            end
        endcase
    end

    // sequencer state advances once per accepted tick beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= '0;
            shift_reg_reg    <= '0;
            wait_count_reg   <= '0;
            held_address_reg <= '0;
            held_data_reg    <= '0;
            is_read_reg      <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            shift_reg_reg    <= shift_reg_next;
            wait_count_reg   <= wait_count_next;
            held_address_reg <= held_address_next;
            held_data_reg    <= held_data_next;
            is_read_reg      <= is_read_next;
        end
    end

    // output register with skid slot
    assign in_ch.ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_fire)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= in_fire;
                end
                else
                begin
                    out_valid_reg <= in_fire;
                end
            end
            else if (in_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (in_fire)
                out_reg <= res;
        end
        if (in_fire && (skid_valid_reg || (out_valid_reg && !out_fire)))
            skid_reg <= res;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.scl_level     = out_reg.scl_level;
    assign out_ch.sda_drive     = out_reg.sda_drive;
    assign out_ch.busy_res      = out_reg.busy_res;
    assign out_ch.done_res      = out_reg.done_res;
    assign out_ch.read_byte_out = out_reg.read_byte_out;
    assign out_ch.nack_error    = out_reg.nack_error;

endmodule
